FILE: sv/tbpe_pkg.sv
// package: widths, register codes, config and job types for the tape block pulse encoder
package tbpe_pkg;

  localparam int unsigned LenW     = 16;
  localparam int unsigned CntW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned BitIdxW  = 3;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [LenW-1:0] MinLen = LenW'(2);

  localparam logic [LenW-1:0] PilotLenRst  = LenW'(619);
  localparam logic [LenW-1:0] Sync1LenRst  = LenW'(191);
  localparam logic [LenW-1:0] Sync2LenRst  = LenW'(210);
  localparam logic [LenW-1:0] ZeroLenRst   = LenW'(244);
  localparam logic [LenW-1:0] OneLenRst    = LenW'(489);
  localparam logic [CntW-1:0] HdrCntRst    = CntW'(8063);
  localparam logic [CntW-1:0] DataCntRst   = CntW'(3223);
  localparam logic            AppendCsRst  = 1'b1;

  localparam logic [CntW-1:0] SyncCount = CntW'(1);
  localparam logic [CntW-1:0] BitCount  = CntW'(2);
  localparam logic [ByteW-1:0] HeaderFlag = ByteW'(0);

  typedef enum logic [CfgIdxW-1:0] {
    REG_PILOT_LEN  = 3'd0,
    REG_SYNC1_LEN  = 3'd1,
    REG_SYNC2_LEN  = 3'd2,
    REG_ZERO_LEN   = 3'd3,
    REG_ONE_LEN    = 3'd4,
    REG_HDR_COUNT  = 3'd5,
    REG_DATA_COUNT = 3'd6,
    REG_APPEND_CS  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_PILOT,
    PH_SYNC1,
    PH_SYNC2,
    PH_DATA,
    PH_CSUM
  } phase_e;

  typedef struct packed {
    logic [LenW-1:0] pilot_len;
    logic [LenW-1:0] sync1_len;
    logic [LenW-1:0] sync2_len;
    logic [LenW-1:0] zero_len;
    logic [LenW-1:0] one_len;
    logic [CntW-1:0] hdr_count;
    logic [CntW-1:0] data_count;
    logic            append_cs;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             first;
    logic             last;
    logic             is_header;
    logic [ByteW-1:0] csum;
  } job_t;

  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v);
    return (v < MinLen) ? MinLen : v;
  endfunction

endpackage

FILE: sv/tbpe_if.sv
// interfaces: byte input channel and pulse run output channel
interface tbpe_in_if;
  logic                      valid;
  logic                      ready;
  logic [tbpe_pkg::ByteW-1:0] data_byte;
  logic                      first_byte;
  logic                      last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface tbpe_out_if;
  logic                      valid;
  logic                      ready;
  logic [tbpe_pkg::LenW-1:0] pulse_us;
  logic [tbpe_pkg::CntW-1:0] pulse_count;
  logic                      start_level;
  logic                      run_last;
  logic                      block_done;

  modport source (output valid, output pulse_us, output pulse_count, output start_level,
                  output run_last, output block_done, input ready);
  modport sink (input valid, input pulse_us, input pulse_count, input start_level,
                input run_last, input block_done, output ready);
endinterface

FILE: sv/tbpe_front.sv
// front end: accepts bytes, keeps the running checksum, builds jobs for the queue
module tbpe_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  tbpe_in_if.sink          in_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output tbpe_pkg::job_t   push_job_o
);
  import tbpe_pkg::*;

  logic [ByteW-1:0] csum_q, csum_d;
  logic             accept;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  always_comb begin
    csum_d = in_i.first_byte ? in_i.data_byte : (csum_q ^ in_i.data_byte);
  end

  always_comb begin
    push_job_o.data_byte = in_i.data_byte;
    push_job_o.first     = in_i.first_byte;
    push_job_o.last      = in_i.last_byte;
    push_job_o.is_header = (in_i.data_byte == HeaderFlag);
    push_job_o.csum      = csum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q <= '0;
    end else if (accept) begin
      csum_q <= csum_d;
    end
  end

endmodule

FILE: sv/tbpe_queue.sv
// job queue between front end and run generator
module tbpe_queue #(
  parameter int unsigned Depth = tbpe_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tbpe_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  output tbpe_pkg::job_t pop_job_o,
  input  logic           pop_i
);
  import tbpe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW2 = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW2-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign push_ready_o = (fill_q != CntW2'(Depth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CntW2'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - CntW2'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: sv/tbpe_back.sv
// back end: walks a job through pilot, sync, data and checksum runs
module tbpe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tbpe_pkg::cfg_t cfg_i,
  input  logic           job_valid_i,
  input  tbpe_pkg::job_t job_i,
  output logic           job_pop_o,
  tbpe_out_if.source     out_o
);
  import tbpe_pkg::*;

  phase_e             phase_q, phase_d, cur_phase, start_phase;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic               busy_q, busy_d;
  logic               level_q, level_d;
  logic               fire, job_end, with_cs;
  logic [CntW-1:0]    pilot_cnt;
  logic [LenW-1:0]    run_len;
  logic [CntW-1:0]    run_cnt;
  logic               run_last;

  logic               out_valid_q;
  logic [LenW-1:0]    pulse_us_q;
  logic [CntW-1:0]    pulse_count_q;
  logic               start_level_q, run_last_q, block_done_q;

  assign pilot_cnt = job_i.is_header ? cfg_i.hdr_count : cfg_i.data_count;
  assign with_cs   = job_i.last && cfg_i.append_cs;
  assign fire      = job_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    if (!job_i.first) begin
      start_phase = PH_DATA;
    end else if (pilot_cnt != '0) begin
      start_phase = PH_PILOT;
    end else begin
      start_phase = PH_SYNC1;
    end
    cur_phase = busy_q ? phase_q : start_phase;
  end

  always_comb begin
    phase_d  = cur_phase;
    bit_d    = bit_q;
    busy_d   = busy_q;
    level_d  = level_q;
    run_len  = cfg_i.zero_len;
    run_cnt  = BitCount;
    run_last = 1'b0;
    job_end  = 1'b0;
    case (cur_phase)
      PH_PILOT: begin
        run_len = cfg_i.pilot_len;
        run_cnt = pilot_cnt;
        phase_d = PH_SYNC1;
      end
      PH_SYNC1: begin
        run_len = cfg_i.sync1_len;
        run_cnt = SyncCount;
        phase_d = PH_SYNC2;
      end
      PH_SYNC2: begin
        run_len = cfg_i.sync2_len;
        run_cnt = SyncCount;
        phase_d = PH_DATA;
      end
      PH_DATA: begin
        run_len = job_i.data_byte[~bit_q] ? cfg_i.one_len : cfg_i.zero_len;
        bit_d   = bit_q + BitIdxW'(1);
        if (bit_q == '1) begin
          if (with_cs) begin
            phase_d = PH_CSUM;
          end else begin
            job_end  = 1'b1;
            run_last = 1'b1;
          end
        end
      end
      PH_CSUM: begin
        run_len = job_i.csum[~bit_q] ? cfg_i.one_len : cfg_i.zero_len;
        bit_d   = bit_q + BitIdxW'(1);
        if (bit_q == '1) begin
          job_end  = 1'b1;
          run_last = 1'b1;
        end
      end
      default: begin
        job_end = 1'b1;
      end
    endcase
    if (fire) begin
      level_d = level_q ^ run_cnt[0];
      busy_d  = !job_end;
      if (job_end) begin
        bit_d = '0;
      end
    end else begin
      phase_d = phase_q;
      bit_d   = bit_q;
    end
  end

  assign job_pop_o = fire && job_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      bit_q       <= '0;
      busy_q      <= 1'b0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      busy_q  <= busy_d;
      level_q <= level_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pulse_us_q    <= clamp_len(run_len);
      pulse_count_q <= run_cnt;
      start_level_q <= ~level_q;
      run_last_q    <= run_last;
      block_done_q  <= run_last && job_i.last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pulse_us    = pulse_us_q;
  assign out_o.pulse_count = pulse_count_q;
  assign out_o.start_level = start_level_q;
  assign out_o.run_last    = run_last_q;
  assign out_o.block_done  = block_done_q;

endmodule

FILE: sv/tape_block_pulse_encoder_top.sv
// top level: config registers, front end, job queue and run generator
//
//   port    dir  word                                               handshake
//   in_i    in   data_byte, first_byte, last_byte                   valid/ready
//   out_o   out  pulse_us, pulse_count, start_level, run_last,      valid/ready
//                block_done
//   cfg     in   cfg_we_i, cfg_idx_i, cfg_data_i                    write enable only
//
// one run leaves per cycle from the run generator unless stalled; a byte's runs are drawn
// from (pilot, two syncs, eight bit runs, eight checksum runs), set by that generator
// the front end accepts a byte per cycle until the job queue is full
// a stalled output holds its run register and the generator waits behind it
// reset: async active low; config returns to its defaults, checksum and line level to zero
module tape_block_pulse_encoder_top #(
  parameter int unsigned QueueDepth = tbpe_pkg::QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbpe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tbpe_pkg::CfgDataW-1:0]  cfg_data_i,
  tbpe_in_if.sink                        in_i,
  tbpe_out_if.source                     out_o
);
  import tbpe_pkg::*;

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop;
  job_t push_job, pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pilot_len  <= PilotLenRst;
      cfg_q.sync1_len  <= Sync1LenRst;
      cfg_q.sync2_len  <= Sync2LenRst;
      cfg_q.zero_len   <= ZeroLenRst;
      cfg_q.one_len    <= OneLenRst;
      cfg_q.hdr_count  <= HdrCntRst;
      cfg_q.data_count <= DataCntRst;
      cfg_q.append_cs  <= AppendCsRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PILOT_LEN:  cfg_q.pilot_len  <= cfg_data_i;
        REG_SYNC1_LEN:  cfg_q.sync1_len  <= cfg_data_i;
        REG_SYNC2_LEN:  cfg_q.sync2_len  <= cfg_data_i;
        REG_ZERO_LEN:   cfg_q.zero_len   <= cfg_data_i;
        REG_ONE_LEN:    cfg_q.one_len    <= cfg_data_i;
        REG_HDR_COUNT:  cfg_q.hdr_count  <= cfg_data_i;
        REG_DATA_COUNT: cfg_q.data_count <= cfg_data_i;
        REG_APPEND_CS:  cfg_q.append_cs  <= cfg_data_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  tbpe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  tbpe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_i        (pop)
  );

  tbpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

FILE: test/tape_block_pulse_encoder_top_tb.sv
// testbench: tape block pulse encoder, predicted pulse runs checked under random idling and stalls
`timescale 1ns / 1ps

module tape_block_pulse_encoder_top_tb;
  import tbpe_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic [LenW-1:0] pulse_us;
    logic [CntW-1:0] pulse_count;
    logic            start_level;
    logic            run_last;
    logic            block_done;
  } pulse_run_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  tbpe_in_if  in_if ();
  tbpe_out_if out_if ();

  tape_block_pulse_encoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  cfg_t            tape_cfg;
  logic [ByteW-1:0] tape_csum;
  logic            line_lvl;
  pulse_run_t      due_runs[$];
  pulse_run_t      byte_runs[$];

  int err_cnt = 0;
  int bytes_taken = 0;
  int runs_seen = 0;
  int settings_used = 1;
  int cycle_cnt = 0;
  int in_gap_max = 0;
  int out_stall_max = 0;
  int hold_req = 0;

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.first_byte = 1'b0;
    in_if.last_byte = 1'b0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // pulse run prediction
  task automatic add_run(input logic [LenW-1:0] len, input logic [CntW-1:0] cnt);
    pulse_run_t r;
    r.pulse_us = (len < MinLen) ? MinLen : len;
    r.pulse_count = cnt;
    r.start_level = ~line_lvl;
    r.run_last = 1'b0;
    r.block_done = 1'b0;
    byte_runs.push_back(r);
    line_lvl = line_lvl ^ cnt[0];
  endtask

  task automatic add_bit_runs(input logic [ByteW-1:0] b);
    for (int i = ByteW - 1; i >= 0; i--) begin
      add_run(b[i] ? tape_cfg.one_len : tape_cfg.zero_len, BitCount);
    end
  endtask

  task automatic encode_byte(input logic [ByteW-1:0] b, input logic first, input logic last);
    logic [CntW-1:0] pilot_cnt;
    byte_runs.delete();
    if (first) begin
      pilot_cnt = (b == HeaderFlag) ? tape_cfg.hdr_count : tape_cfg.data_count;
      if (pilot_cnt != '0) add_run(tape_cfg.pilot_len, pilot_cnt);
      add_run(tape_cfg.sync1_len, SyncCount);
      add_run(tape_cfg.sync2_len, SyncCount);
      tape_csum = b;
    end else begin
      tape_csum = tape_csum ^ b;
    end
    add_bit_runs(b);
    if (last && tape_cfg.append_cs) add_bit_runs(tape_csum);
    byte_runs[byte_runs.size() - 1].run_last = 1'b1;
    byte_runs[byte_runs.size() - 1].block_done = last;
    foreach (byte_runs[i]) due_runs.push_back(byte_runs[i]);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      encode_byte(in_if.data_byte, in_if.first_byte, in_if.last_byte);
      bytes_taken++;
    end
  end

  always @(posedge clk_i) begin : check_runs
    pulse_run_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      runs_seen++;
      if (due_runs.size() == 0) begin
        $error("pulse run with none expected: us %0d count %0d", out_if.pulse_us,
               out_if.pulse_count);
        err_cnt++;
      end else begin
        want = due_runs.pop_front();
        if (out_if.pulse_us !== want.pulse_us) begin
          $error("pulse_us: expected %0d, got %0d", want.pulse_us, out_if.pulse_us);
          err_cnt++;
        end
        if (out_if.pulse_count !== want.pulse_count) begin
          $error("pulse_count: expected %0d, got %0d", want.pulse_count, out_if.pulse_count);
          err_cnt++;
        end
        if (out_if.start_level !== want.start_level) begin
          $error("start_level: expected %0b, got %0b", want.start_level, out_if.start_level);
          err_cnt++;
        end
        if (out_if.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_if.run_last);
          err_cnt++;
        end
        if (out_if.block_done !== want.block_done) begin
          $error("block_done: expected %0b, got %0b", want.block_done, out_if.block_done);
          err_cnt++;
        end
      end
    end
  end

  // run receiver with random stalls and an occasional long hold
  initial begin : take_runs
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end
      stall = (out_stall_max > 0) ? $urandom_range(0, out_stall_max) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic first, input logic last);
    int gap;
    gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.first_byte <= first;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (due_runs.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input cfg_t c);
    logic [CfgDataW-1:0] vals[8];
    vals[REG_PILOT_LEN] = c.pilot_len;
    vals[REG_SYNC1_LEN] = c.sync1_len;
    vals[REG_SYNC2_LEN] = c.sync2_len;
    vals[REG_ZERO_LEN] = c.zero_len;
    vals[REG_ONE_LEN] = c.one_len;
    vals[REG_HDR_COUNT] = c.hdr_count;
    vals[REG_DATA_COUNT] = c.data_count;
    // upper bits of the flag register are junk on purpose
    vals[REG_APPEND_CS] = {(CfgDataW - 1)'($urandom_range(0, 32767)), c.append_cs};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= reg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    tape_cfg = c;
    settings_used++;
  endtask

  function automatic logic [LenW-1:0] pick_len();
    case ($urandom_range(0, 7))
      0: return LenW'($urandom_range(0, 3));
      1: return '1;
      default: return LenW'($urandom_range(2, 65535));
    endcase
  endfunction

  function automatic logic [CntW-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return CntW'(1);
      default: return CntW'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic test_default_blocks();
    // byte outside a block, then a header block, a data block, a single byte block and a last byte outside a block
    send_byte(8'h3C, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);
    send_byte(8'h7E, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_short_lengths();
    cfg_t c;
    c = '{pilot_len: 16'd0, sync1_len: 16'd1, sync2_len: 16'd2, zero_len: 16'd1,
          one_len: 16'd0, hdr_count: 16'd0, data_count: 16'd1, append_cs: 1'b0};
    set_config(c);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
    send_byte(8'h01, 1'b1, 1'b1);
    send_byte(8'hC3, 1'b1, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_long_lengths();
    cfg_t c;
    c = '{pilot_len: '1, sync1_len: '1, sync2_len: '1, zero_len: '1, one_len: 16'd3,
          hdr_count: '1, data_count: 16'd0, append_cs: 1'b1};
    set_config(c);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFE, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_output_hold();
    cfg_t c;
    c = '{pilot_len: PilotLenRst, sync1_len: Sync1LenRst, sync2_len: Sync2LenRst,
          zero_len: ZeroLenRst, one_len: OneLenRst, hdr_count: HdrCntRst,
          data_count: DataCntRst, append_cs: AppendCsRst};
    set_config(c);
    in_gap_max = 0;
    out_stall_max = 0;
    hold_req = HoldCycles;
    for (int i = 0; i < 12; i++) begin
      send_byte(ByteW'($urandom_range(0, 255)), i == 0, i == 11);
    end
    wait_drained();
  endtask

  task automatic test_random_blocks(input int n_bytes, input int gap_max, input int stall_max);
    cfg_t c;
    int start_cnt;
    int blk_len;
    logic [ByteW-1:0] b;
    c = '{pilot_len: pick_len(), sync1_len: pick_len(), sync2_len: pick_len(),
          zero_len: pick_len(), one_len: pick_len(), hdr_count: pick_count(),
          data_count: pick_count(), append_cs: 1'($urandom_range(0, 1))};
    set_config(c);
    in_gap_max = gap_max;
    out_stall_max = stall_max;
    start_cnt = bytes_taken;
    while (bytes_taken - start_cnt < n_bytes) begin
      if ($urandom_range(0, 9) < 8) begin
        blk_len = $urandom_range(1, 6);
        for (int i = 0; i < blk_len; i++) begin
          b = ByteW'($urandom_range(0, 255));
          if (i == 0 && $urandom_range(0, 2) == 0) b = HeaderFlag;
          send_byte(b, i == 0, i == blk_len - 1);
        end
      end else begin
        send_byte(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
    end
    wait_drained();
  endtask

  initial begin
    tape_cfg = '{pilot_len: PilotLenRst, sync1_len: Sync1LenRst, sync2_len: Sync2LenRst,
                 zero_len: ZeroLenRst, one_len: OneLenRst, hdr_count: HdrCntRst,
                 data_count: DataCntRst, append_cs: AppendCsRst};
    tape_csum = '0;
    line_lvl = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_blocks();
    test_short_lengths();
    test_long_lengths();
    test_output_hold();
    test_random_blocks(18, 0, 0);
    test_random_blocks(18, 12, 0);
    test_random_blocks(18, 0, 12);
    test_random_blocks(18, 12, 12);

    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d bytes and %0d pulse runs over %0d register settings,", bytes_taken,
             runs_seen, settings_used);
    $display("with header, data, single byte and stray bytes under idling and a long hold");
    if (err_cnt == 0 && due_runs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
